### src/mbtp_pkg.sv
// ----------------------------------------------------------------------------
// mbtp_pkg: shared types and constants for the tileable mirror blend unit
// Field widths, register decode, pipeline payload types and the division
// step helpers used by the restoring divider stages.
// ----------------------------------------------------------------------------
package mbtp_pkg;

  localparam int COORD_W = 12;
  localparam int PIX_W   = 24;
  localparam int CH_W    = 8;
  localparam int NCH     = PIX_W / CH_W;
  localparam int DIM_W   = 13;
  localparam int HALF_W  = DIM_W - 1;
  localparam int WGT_W   = 19;             // |half - pos| * 100 over a half of 1
  localparam int WSUM_W  = WGT_W + 1;
  localparam int DEN_W   = WSUM_W + 1;
  localparam int PROD_W  = WSUM_W + CH_W;
  localparam int NUM_W   = PROD_W + 1;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int REG_ADDR_LSB = 2;

  localparam logic [DIM_W-1:0] MAX_DIM   = DIM_W'(4096);
  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);
  localparam logic [WGT_W-1:0] WGT_SCALE = WGT_W'(100);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   p;
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
  } item_t;

  // Partial remainder plus dividend bits that turn into quotient bits
  typedef struct packed {
    logic [HALF_W-1:0] rem;
    logic [WGT_W-1:0]  nq;
  } div1_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [CH_W-1:0]  nq;
  } div2_t;

  typedef struct packed {
    item_t            it;
    logic [WGT_W-1:0] nx;
    logic [WGT_W-1:0] ny;
  } s1_t;

  typedef struct packed {
    item_t it;
    div1_t dx;
    div1_t dy;
  } d1_stage_t;

  typedef struct packed {
    logic [COORD_W-1:0]          x;
    logic [COORD_W-1:0]          y;
    logic [PIX_W-1:0]            p;
    logic [NCH-1:0][PROD_W-1:0]  pa;
    logic [NCH-1:0][PROD_W-1:0]  pb;
    logic [NCH-1:0][PROD_W-1:0]  pc;
    logic [DEN_W-1:0]            den;
    logic                        bz;
  } m1_t;

  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [PIX_W-1:0]    p;
    logic [DEN_W-1:0]    den;
    logic                bz;
    div2_t [NCH-1:0]     ch;
  } d2_stage_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   pix;
  } res_t;

  function automatic logic [WGT_W-1:0] dist_scaled(input logic [HALF_W-1:0]  half,
                                                   input logic [COORD_W-1:0] pos);
    logic [HALF_W-1:0] offs;
    offs = (half >= pos) ? (half - pos) : (pos - half);
    return WGT_W'(offs) * WGT_SCALE;
  endfunction

  function automatic div1_t div1_step(input div1_t a, input logic [HALF_W-1:0] d);
    logic [HALF_W:0] trial;
    div1_t           r;
    trial = {a.rem, a.nq[WGT_W-1]};
    if (trial >= {1'b0, d}) begin
      r.rem = HALF_W'(trial - {1'b0, d});
      r.nq  = {a.nq[WGT_W-2:0], 1'b1};
    end else begin
      r.rem = trial[HALF_W-1:0];
      r.nq  = {a.nq[WGT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic div2_t div2_step(input div2_t a, input logic [DEN_W-1:0] d);
    logic [DEN_W:0] trial;
    div2_t          r;
    trial = {a.rem, a.nq[CH_W-1]};
    if (trial >= {1'b0, d}) begin
      r.rem = DEN_W'(trial - {1'b0, d});
      r.nq  = {a.nq[CH_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DEN_W-1:0];
      r.nq  = {a.nq[CH_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### src/mirror_blend_tileable_pixel_unit.sv
// ----------------------------------------------------------------------------
// mirror_blend_tileable_pixel_unit: tileable-image pixel blender
// Weights each pixel against its horizontal and vertical mirrors by distance
// from the image center and returns the truncated weighted mean per channel.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+-------------------
//  in_      | valid/ready, x/y, pixel + two mirrors     | pixel beats in
//  out_     | valid/ready, x/y, blended pixel           | pixel beats out
//  cfg_     | APB: psel/penable/pwrite/paddr/pwdata ... | width, height
//
// One beat per cycle sustained while the skid register is empty. The pipe
// is an input stage, 19 weight divider stages (one quotient bit each), two
// multiply/add stages, 8 blend divider stages (one quotient bit each) and
// the output register. rst_n is synchronous; it clears all valid bits and
// sets width and height to 256. Output stalls are absorbed by a one-beat
// skid register; in_ready drops only while that skid register is occupied.
// ----------------------------------------------------------------------------
module mirror_blend_tileable_pixel_unit
  import mbtp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input beats
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [COORD_W-1:0]  in_x_pos,
  input  logic [COORD_W-1:0]  in_y_pos,
  input  logic [PIX_W-1:0]    in_pixel_here,
  input  logic [PIX_W-1:0]    in_pixel_mirror_x,
  input  logic [PIX_W-1:0]    in_pixel_mirror_y,
  // result beats
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  out_x_out,
  output logic [COORD_W-1:0]  out_y_out,
  output logic [PIX_W-1:0]    out_pixel_out,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [APB_AW-1:0]   cfg_paddr,
  input  logic [APB_DW-1:0]   cfg_pwdata,
  output logic [APB_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  localparam int D1_STAGES = WGT_W;
  localparam int D2_STAGES = CH_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [DIM_W-1:0] wdim, wdim_sat;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[REG_ADDR_LSB]);
  assign wdim       = cfg_pwdata[DIM_W-1:0];
  assign wdim_sat   = (wdim > MAX_DIM) ? MAX_DIM : wdim;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH:  width_nxt  = wdim_sat;
        REG_HEIGHT: height_nxt = wdim_sat;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  cfg_prdata = APB_DW'(width_r);
      REG_HEIGHT: cfg_prdata = APB_DW'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  logic [HALF_W-1:0] half_w, half_h;
  assign half_w = width_r[DIM_W-1:1];
  assign half_h = height_r[DIM_W-1:1];

  // --------------------------------------------------------------------------
  // Pipeline control: whole pipe moves together, bubbles included
  // --------------------------------------------------------------------------
  logic pipe_en;
  logic skid_v_r, skid_v_nxt;

  assign pipe_en  = ~skid_v_r;
  assign in_ready = pipe_en;

  // --------------------------------------------------------------------------
  // Input stage: |half - pos| * 100
  // --------------------------------------------------------------------------
  s1_t  s1_r, s1_nxt;
  logic s1_v_r;

  always_comb begin
    s1_nxt.it.x  = in_x_pos;
    s1_nxt.it.y  = in_y_pos;
    s1_nxt.it.p  = in_pixel_here;
    s1_nxt.it.px = in_pixel_mirror_x;
    s1_nxt.it.py = in_pixel_mirror_y;
    s1_nxt.nx    = dist_scaled(half_w, in_x_pos);
    s1_nxt.ny    = dist_scaled(half_h, in_y_pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (pipe_en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_r <= s1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Weight dividers: one quotient bit per stage, x and y side by side
  // --------------------------------------------------------------------------
  d1_stage_t d1_r   [D1_STAGES];
  d1_stage_t d1_nxt [D1_STAGES];
  logic [D1_STAGES-1:0] d1_v_r;

  for (genvar k = 0; k < D1_STAGES; k++) begin : g_d1
    d1_stage_t src;
    logic      src_v;

    if (k == 0) begin : g_first
      assign src.it     = s1_r.it;
      assign src.dx.rem = '0;
      assign src.dx.nq  = s1_r.nx;
      assign src.dy.rem = '0;
      assign src.dy.nq  = s1_r.ny;
      assign src_v      = s1_v_r;
    end else begin : g_next
      assign src   = d1_r[k-1];
      assign src_v = d1_v_r[k-1];
    end

    always_comb begin
      d1_nxt[k].it = src.it;
      d1_nxt[k].dx = div1_step(src.dx, half_w);
      d1_nxt[k].dy = div1_step(src.dy, half_h);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d1_v_r[k] <= 1'b0;
      end else if (pipe_en) begin
        d1_v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        d1_r[k] <= d1_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Products of weights and channels
  // --------------------------------------------------------------------------
  d1_stage_t         d1_last;
  logic [WGT_W-1:0]  wx, wy;
  logic [WSUM_W-1:0] wsum;
  m1_t               m1_r, m1_nxt;
  logic              m1_v_r;

  assign d1_last = d1_r[D1_STAGES-1];
  // a zero half dimension forces its weight to zero
  assign wx      = (half_w == '0) ? '0 : d1_last.dx.nq;
  assign wy      = (half_h == '0) ? '0 : d1_last.dy.nq;
  assign wsum    = WSUM_W'(wx) + WSUM_W'(wy);

  always_comb begin
    m1_nxt.x   = d1_last.it.x;
    m1_nxt.y   = d1_last.it.y;
    m1_nxt.p   = d1_last.it.p;
    m1_nxt.den = {wsum, 1'b0};
    m1_nxt.bz  = (wsum == '0);
    for (int c = 0; c < NCH; c++) begin
      m1_nxt.pa[c] = PROD_W'(wsum) * PROD_W'(d1_last.it.p[CH_W*c +: CH_W]);
      m1_nxt.pb[c] = PROD_W'(wx) * PROD_W'(d1_last.it.px[CH_W*c +: CH_W]);
      m1_nxt.pc[c] = PROD_W'(wy) * PROD_W'(d1_last.it.py[CH_W*c +: CH_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (pipe_en) begin
      m1_v_r <= d1_v_r[D1_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m1_r <= m1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Numerator sums, split into starting remainder and quotient bits
  // --------------------------------------------------------------------------
  d2_stage_t        m2_r, m2_nxt;
  logic             m2_v_r;
  logic [NUM_W-1:0] num [NCH];

  always_comb begin
    m2_nxt.x   = m1_r.x;
    m2_nxt.y   = m1_r.y;
    m2_nxt.p   = m1_r.p;
    m2_nxt.den = m1_r.den;
    m2_nxt.bz  = m1_r.bz;
    for (int c = 0; c < NCH; c++) begin
      num[c] = NUM_W'(m1_r.pa[c]) + NUM_W'(m1_r.pb[c]) + NUM_W'(m1_r.pc[c]);
      // quotient fits in one channel, so the high part is already below den
      m2_nxt.ch[c].rem = num[c][NUM_W-1:CH_W];
      m2_nxt.ch[c].nq  = num[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (pipe_en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m2_r <= m2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Blend dividers: one quotient bit per stage, three channels side by side
  // --------------------------------------------------------------------------
  d2_stage_t d2_r   [D2_STAGES];
  d2_stage_t d2_nxt [D2_STAGES];
  logic [D2_STAGES-1:0] d2_v_r;

  for (genvar k = 0; k < D2_STAGES; k++) begin : g_d2
    d2_stage_t src;
    logic      src_v;

    if (k == 0) begin : g_first
      assign src   = m2_r;
      assign src_v = m2_v_r;
    end else begin : g_next
      assign src   = d2_r[k-1];
      assign src_v = d2_v_r[k-1];
    end

    always_comb begin
      d2_nxt[k].x   = src.x;
      d2_nxt[k].y   = src.y;
      d2_nxt[k].p   = src.p;
      d2_nxt[k].den = src.den;
      d2_nxt[k].bz  = src.bz;
      for (int c = 0; c < NCH; c++) begin
        d2_nxt[k].ch[c] = div2_step(src.ch[c], src.den);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d2_v_r[k] <= 1'b0;
      end else if (pipe_en) begin
        d2_v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        d2_r[k] <= d2_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result select and output buffer (output register plus skid)
  // --------------------------------------------------------------------------
  d2_stage_t        d2_last;
  logic [PIX_W-1:0] blend_pix;
  res_t             fin;
  logic             push;
  res_t             out_r, out_nxt;
  res_t             skid_r, skid_nxt;
  logic             out_v_r, out_v_nxt;

  assign d2_last = d2_r[D2_STAGES-1];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      blend_pix[CH_W*c +: CH_W] = d2_last.ch[c].nq;
    end
  end

  // both weights zero: pixel passes through
  assign fin.x   = d2_last.x;
  assign fin.y   = d2_last.y;
  assign fin.pix = d2_last.bz ? d2_last.p : blend_pix;
  assign push    = pipe_en & d2_v_r[D2_STAGES-1];

  always_comb begin
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = push;
        out_nxt   = fin;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_x_out     = out_r.x;
  assign out_y_out     = out_r.y;
  assign out_pixel_out = out_r.pix;

endmodule
